FILE: src/pixel_format_convert_writer_assert.svh
// ----------------------------------------------------------------------------
// pixel format convert writer assertion macros
// shared property forms for the writer's concurrent checks
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERT_WRITER_ASSERT_SVH
`define PIXEL_FORMAT_CONVERT_WRITER_ASSERT_SVH

// ante must always bring cons in the same cycle
`define PFCW_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cond must never hold
`define PFCW_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

FILE: src/pfcw_pkg.sv
// ----------------------------------------------------------------------------
// pfcw_pkg
// types, sizes and codes shared by the pixel format convert writer
// ----------------------------------------------------------------------------
`default_nettype none

package pfcw_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int SIZE_W      = 13;
  localparam int STRIDE0_W   = 14;
  localparam int STRIDE12_W  = 13;
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_INDEX_W = 3;
  localparam int ADDR_W      = 26;

  localparam int DIM_A  = (COL_W > ROW_W) ? COL_W + 1 : ROW_W + 1;
  localparam int DIM_W  = (SIZE_W > DIM_A) ? SIZE_W : DIM_A;
  localparam int PROD_W = ROW_W + STRIDE0_W;
  localparam int SUM_A  = (PROD_W + 1 > COL_W + 3) ? PROD_W + 1 : COL_W + 3;
  localparam int SUM_W  = (SUM_A > ADDR_W + 1) ? SUM_A : ADDR_W + 1;

  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_PACKED,
    MODE_PLANAR,
    MODE_YUV420,
    MODE_GREY
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MODE,
    CFG_SWAP,
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_STRIDE0,
    CFG_STRIDE1,
    CFG_STRIDE2
  } cfg_index_t;

  localparam logic [1:0] PLANE0 = 2'd0;
  localparam logic [1:0] PLANE1 = 2'd1;
  localparam logic [1:0] PLANE2 = 2'd2;

  typedef struct packed {
    mode_t                  mode;
    logic                   swap_outer;
    logic [SIZE_W-1:0]      image_width;
    logic [SIZE_W-1:0]      image_height;
    logic [STRIDE0_W-1:0]   plane0_stride;
    logic [STRIDE12_W-1:0]  plane1_stride;
    logic [STRIDE12_W-1:0]  plane2_stride;
  } cfg_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
  } pixel_t;

  typedef struct packed {
    logic [1:0]        plane_select;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        data_byte;
    logic              last_of_pixel;
    logic              frame_end;
  } write_t;

  typedef struct packed {
    mode_t            mode;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic             fend;
  } desc_t;

endpackage

`default_nettype wire

FILE: src/pfcw_front.sv
// ----------------------------------------------------------------------------
// pfcw_front
// accepts pixels, tracks column and row, builds a work descriptor
// ----------------------------------------------------------------------------
`default_nettype none

module pfcw_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pfcw_pkg::cfg_t  cfg,
  input  wire logic            push,
  input  wire pfcw_pkg::pixel_t pixel,
  input  wire logic            queue_full,
  output logic                 desc_push,
  output pfcw_pkg::desc_t      desc
);

  logic [pfcw_pkg::COL_W-1:0] column_count, column_count_next;
  logic [pfcw_pkg::ROW_W-1:0] row_count, row_count_next;

  logic [pfcw_pkg::DIM_W-1:0] w_eff, h_eff, w_raw, h_raw;
  logic [pfcw_pkg::DIM_W-1:0] row_t, col_inc, row_inc;
  logic [pfcw_pkg::COL_W-1:0] col_s;
  logic [pfcw_pkg::ROW_W-1:0] row_s;
  logic                       wrap_in, end_row, fend, do_swap, accept;

  assign accept    = push && !queue_full;
  assign desc_push = accept;

  // effective size: zero acts as one, clamp to the maximum
  always_comb begin
    w_raw = pfcw_pkg::DIM_W'(cfg.image_width);
    h_raw = pfcw_pkg::DIM_W'(cfg.image_height);
    if (w_raw == '0) begin
      w_eff = pfcw_pkg::DIM_W'(1);
    end else if (w_raw > pfcw_pkg::DIM_W'(pfcw_pkg::MAX_WIDTH)) begin
      w_eff = pfcw_pkg::DIM_W'(pfcw_pkg::MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = pfcw_pkg::DIM_W'(1);
    end else if (h_raw > pfcw_pkg::DIM_W'(pfcw_pkg::MAX_HEIGHT)) begin
      h_eff = pfcw_pkg::DIM_W'(pfcw_pkg::MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  // position of this pixel, after wrapping counters left outside a shrunk size
  always_comb begin
    wrap_in = pfcw_pkg::DIM_W'(column_count) >= w_eff;
    col_s   = wrap_in ? '0 : column_count;
    row_t   = wrap_in ? pfcw_pkg::DIM_W'(row_count) + pfcw_pkg::DIM_W'(1)
                      : pfcw_pkg::DIM_W'(row_count);
    row_s   = (row_t >= h_eff) ? '0 : pfcw_pkg::ROW_W'(row_t);
    fend    = (pfcw_pkg::DIM_W'(col_s) == w_eff - pfcw_pkg::DIM_W'(1)) &&
              (pfcw_pkg::DIM_W'(row_s) == h_eff - pfcw_pkg::DIM_W'(1));
    col_inc = pfcw_pkg::DIM_W'(col_s) + pfcw_pkg::DIM_W'(1);
    row_inc = pfcw_pkg::DIM_W'(row_s) + pfcw_pkg::DIM_W'(1);
    end_row = col_inc >= w_eff;
  end

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (accept) begin
      if (end_row) begin
        column_count_next = '0;
        row_count_next    = (row_inc >= h_eff) ? '0 : pfcw_pkg::ROW_W'(row_inc);
      end else begin
        column_count_next = pfcw_pkg::COL_W'(col_inc);
        row_count_next    = row_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  assign do_swap = cfg.swap_outer && (cfg.mode != pfcw_pkg::MODE_GREY);

  always_comb begin
    desc.mode = cfg.mode;
    desc.col  = col_s;
    desc.row  = row_s;
    desc.b0   = do_swap ? pixel.third_byte : pixel.first_byte;
    desc.b1   = pixel.second_byte;
    desc.b2   = do_swap ? pixel.first_byte : pixel.third_byte;
    desc.fend = fend;
  end

endmodule

`default_nettype wire

FILE: src/pfcw_queue.sv
// ----------------------------------------------------------------------------
// pfcw_queue
// short descriptor queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module pfcw_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire pfcw_pkg::desc_t  push_desc,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output pfcw_pkg::desc_t       head
);

  pfcw_pkg::desc_t             entry [pfcw_pkg::QUEUE_DEPTH];
  logic [pfcw_pkg::QPTR_W-1:0] wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next;
  logic [pfcw_pkg::QCNT_W-1:0] count, count_next;
  logic                        do_push, do_pop;

  assign full    = count == pfcw_pkg::QCNT_W'(pfcw_pkg::QUEUE_DEPTH);
  assign valid   = count != '0;
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign head    = entry[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == pfcw_pkg::QPTR_W'(pfcw_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr + pfcw_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == pfcw_pkg::QPTR_W'(pfcw_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr + pfcw_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_next = count + pfcw_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - pfcw_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

endmodule

`default_nettype wire

FILE: src/pfcw_back.sv
// ----------------------------------------------------------------------------
// pfcw_back
// computes row offsets and YUV, then issues one byte write per cycle while the output buffer has room
// ----------------------------------------------------------------------------
`default_nettype none

module pfcw_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pfcw_pkg::cfg_t   cfg,
  input  wire logic             desc_valid,
  input  wire pfcw_pkg::desc_t  desc,
  output logic                  desc_pop,
  output logic                  empty,
  input  wire logic             pop,
  output pfcw_pkg::write_t      result
);

  localparam logic [15:0] Y_R  = 16'd66;
  localparam logic [15:0] Y_G  = 16'd129;
  localparam logic [15:0] Y_B  = 16'd25;
  localparam logic [7:0]  Y_OFS = 8'd16;
  localparam logic [15:0] U_R  = 16'd38;
  localparam logic [15:0] U_G  = 16'd74;
  localparam logic [15:0] U_B  = 16'd112;
  localparam logic [15:0] V_R  = 16'd112;
  localparam logic [15:0] V_G  = 16'd94;
  localparam logic [15:0] V_B  = 16'd18;
  localparam logic [15:0] C_OFS = 16'd32768;

  // calc stage
  logic                          calc_valid, calc_valid_next;
  pfcw_pkg::desc_t               calc_desc;
  logic [pfcw_pkg::PROD_W-1:0]   calc_p0, calc_p1, calc_p2;
  logic [7:0]                    calc_y, calc_u, calc_v;
  logic [1:0]                    calc_last_k;

  // emit stage
  logic                          emit_valid, emit_valid_next;
  logic [1:0]                    emit_k, emit_k_next;
  pfcw_pkg::desc_t               emit_desc;
  logic [pfcw_pkg::PROD_W-1:0]   emit_p0, emit_p1, emit_p2;
  logic [7:0]                    emit_y, emit_u, emit_v;
  logic [1:0]                    emit_last_k;

  // output buffer
  pfcw_pkg::write_t              obuf [2];
  logic                          o_wr, o_wr_next, o_rd, o_rd_next;
  logic [1:0]                    o_count, o_count_next;

  logic [pfcw_pkg::ROW_W-1:0]    row_c;
  logic [15:0]                   y_sum, u_sum, v_sum;
  logic [pfcw_pkg::PROD_W-1:0]   p0_c, p1_c, p2_c;
  logic [1:0]                    last_k_c;
  logic                          chroma_c;

  logic [pfcw_pkg::PROD_W-1:0]   base;
  logic [pfcw_pkg::COL_W+1:0]    off;
  logic [pfcw_pkg::SUM_W-1:0]    sum;
  pfcw_pkg::write_t              wr;

  logic emit_adv, emit_done, emit_free, calc_move, calc_free, o_room, o_pop;

  // handshake between stages
  always_comb begin
    o_room    = o_count != 2'd2;
    o_pop     = pop && (o_count != 2'd0);
    emit_adv  = emit_valid && o_room;
    emit_done = emit_adv && (emit_k == emit_last_k);
    emit_free = !emit_valid || emit_done;
    calc_move = calc_valid && emit_free;
    calc_free = !calc_valid || calc_move;
    desc_pop  = desc_valid && calc_free;
  end

  // row offsets and color conversion
  always_comb begin
    row_c    = (desc.mode == pfcw_pkg::MODE_YUV420) ? (desc.row >> 1) : desc.row;
    p0_c     = pfcw_pkg::PROD_W'(desc.row) * pfcw_pkg::PROD_W'(cfg.plane0_stride);
    p1_c     = pfcw_pkg::PROD_W'(row_c) * pfcw_pkg::PROD_W'(cfg.plane1_stride);
    p2_c     = pfcw_pkg::PROD_W'(row_c) * pfcw_pkg::PROD_W'(cfg.plane2_stride);
    y_sum    = Y_R * 16'(desc.b2) + Y_G * 16'(desc.b1) + Y_B * 16'(desc.b0);
    u_sum    = C_OFS + U_B * 16'(desc.b0) - U_R * 16'(desc.b2) - U_G * 16'(desc.b1);
    v_sum    = C_OFS + V_R * 16'(desc.b2) - V_G * 16'(desc.b1) - V_B * 16'(desc.b0);
    chroma_c = !desc.col[0] && !desc.row[0];
    unique case (desc.mode)
      pfcw_pkg::MODE_PACKED, pfcw_pkg::MODE_PLANAR: last_k_c = 2'd2;
      pfcw_pkg::MODE_YUV420:                        last_k_c = chroma_c ? 2'd2 : 2'd0;
      default:                                      last_k_c = 2'd0;
    endcase
  end

  always_comb begin
    calc_valid_next = desc_pop || (calc_valid && !calc_move);
    emit_valid_next = calc_move || (emit_valid && !emit_done);
    emit_k_next     = emit_k;
    if (calc_move) begin
      emit_k_next = 2'd0;
    end else if (emit_adv && !emit_done) begin
      emit_k_next = emit_k + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calc_valid <= 1'b0;
      emit_valid <= 1'b0;
      emit_k     <= 2'd0;
    end else begin
      calc_valid <= calc_valid_next;
      emit_valid <= emit_valid_next;
      emit_k     <= emit_k_next;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_pop) begin
      calc_desc   <= desc;
      calc_p0     <= p0_c;
      calc_p1     <= p1_c;
      calc_p2     <= p2_c;
      calc_y      <= y_sum[15:8] + Y_OFS;
      calc_u      <= u_sum[15:8];
      calc_v      <= v_sum[15:8];
      calc_last_k <= last_k_c;
    end
    if (calc_move) begin
      emit_desc   <= calc_desc;
      emit_p0     <= calc_p0;
      emit_p1     <= calc_p1;
      emit_p2     <= calc_p2;
      emit_y      <= calc_y;
      emit_u      <= calc_u;
      emit_v      <= calc_v;
      emit_last_k <= calc_last_k;
    end
  end

  // select plane, offset and data for the current write
  always_comb begin
    wr.plane_select = pfcw_pkg::PLANE0;
    base            = emit_p0;
    off             = (pfcw_pkg::COL_W+2)'(emit_desc.col);
    wr.data_byte    = emit_desc.b0;
    case (emit_desc.mode)
      pfcw_pkg::MODE_PACKED: begin
        off = (pfcw_pkg::COL_W+2)'(emit_desc.col) * (pfcw_pkg::COL_W+2)'(3)
              + (pfcw_pkg::COL_W+2)'(emit_k);
        case (emit_k)
          2'd0:    wr.data_byte = emit_desc.b0;
          2'd1:    wr.data_byte = emit_desc.b1;
          default: wr.data_byte = emit_desc.b2;
        endcase
      end
      pfcw_pkg::MODE_PLANAR: begin
        case (emit_k)
          2'd0: begin
            wr.plane_select = pfcw_pkg::PLANE0;
            base            = emit_p0;
            wr.data_byte    = emit_desc.b0;
          end
          2'd1: begin
            wr.plane_select = pfcw_pkg::PLANE1;
            base            = emit_p1;
            wr.data_byte    = emit_desc.b1;
          end
          default: begin
            wr.plane_select = pfcw_pkg::PLANE2;
            base            = emit_p2;
            wr.data_byte    = emit_desc.b2;
          end
        endcase
      end
      pfcw_pkg::MODE_YUV420: begin
        case (emit_k)
          2'd0: begin
            wr.plane_select = pfcw_pkg::PLANE0;
            base            = emit_p0;
            wr.data_byte    = emit_y;
          end
          2'd1: begin
            wr.plane_select = pfcw_pkg::PLANE1;
            base            = emit_p1;
            off             = (pfcw_pkg::COL_W+2)'(emit_desc.col >> 1);
            wr.data_byte    = emit_u;
          end
          default: begin
            wr.plane_select = pfcw_pkg::PLANE2;
            base            = emit_p2;
            off             = (pfcw_pkg::COL_W+2)'(emit_desc.col >> 1);
            wr.data_byte    = emit_v;
          end
        endcase
      end
      default: begin
        wr.data_byte = emit_desc.b0;
      end
    endcase
    sum = pfcw_pkg::SUM_W'(base) + pfcw_pkg::SUM_W'(off);
    wr.byte_address = (sum > pfcw_pkg::SUM_W'(pfcw_pkg::ADDR_MAX))
                      ? pfcw_pkg::ADDR_MAX : pfcw_pkg::ADDR_W'(sum);
    wr.last_of_pixel = emit_k == emit_last_k;
    wr.frame_end     = emit_desc.fend;
  end

  // two-entry output buffer
  always_comb begin
    o_wr_next    = emit_adv ? !o_wr : o_wr;
    o_rd_next    = o_pop ? !o_rd : o_rd;
    o_count_next = o_count;
    if (emit_adv && !o_pop) begin
      o_count_next = o_count + 2'd1;
    end else if (o_pop && !emit_adv) begin
      o_count_next = o_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr    <= 1'b0;
      o_rd    <= 1'b0;
      o_count <= 2'd0;
    end else begin
      o_wr    <= o_wr_next;
      o_rd    <= o_rd_next;
      o_count <= o_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_adv) begin
      obuf[o_wr] <= wr;
    end
  end

  assign empty  = o_count == 2'd0;
  assign result = obuf[o_rd];

endmodule

`default_nettype wire

FILE: src/pixel_format_convert_writer.sv
// ----------------------------------------------------------------------------
// pixel_format_convert_writer
// packed 3-byte pixels in raster order to plane/address/byte writes
//
//   channel   handshake            payload
//   pixel     push / full          pfcw_pkg::pixel_t
//   result    empty / pop          pfcw_pkg::write_t
//   config    cfg_write            cfg_index, cfg_data
//
// one write leaves per cycle while the output buffer has room: packed, planar
// and yuv chroma pixels give three writes, yuv luma-only and grey pixels one
// a pixel is registered in the queue, calc, emit and output buffer in turn
// a two-entry queue and a two-entry output buffer let either side stall
// synchronous reset clears counters and queues and loads defaults into the configuration registers
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_format_convert_writer_assert.svh"

module pixel_format_convert_writer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  output logic                                     full,
  input  wire pfcw_pkg::pixel_t                    pixel,
  output logic                                     empty,
  input  wire logic                                pop,
  output pfcw_pkg::write_t                         result,
  input  wire logic                                cfg_write,
  input  wire logic [pfcw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [pfcw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  pfcw_pkg::cfg_t  cfg, cfg_next;
  pfcw_pkg::desc_t front_desc, queue_head;
  logic            desc_push, desc_pop, queue_valid;
  logic            res_plane0, res_plane1, res_plane2, res_plane_ok;

  always_comb begin
    cfg_next = cfg;
    if (cfg_write) begin
      unique case (cfg_index)
        pfcw_pkg::CFG_MODE:    cfg_next.mode          = pfcw_pkg::mode_t'(cfg_data[1:0]);
        pfcw_pkg::CFG_SWAP:    cfg_next.swap_outer    = cfg_data[0];
        pfcw_pkg::CFG_WIDTH:   cfg_next.image_width   = cfg_data[pfcw_pkg::SIZE_W-1:0];
        pfcw_pkg::CFG_HEIGHT:  cfg_next.image_height  = cfg_data[pfcw_pkg::SIZE_W-1:0];
        pfcw_pkg::CFG_STRIDE0: cfg_next.plane0_stride = cfg_data[pfcw_pkg::STRIDE0_W-1:0];
        pfcw_pkg::CFG_STRIDE1: cfg_next.plane1_stride = cfg_data[pfcw_pkg::STRIDE12_W-1:0];
        pfcw_pkg::CFG_STRIDE2: cfg_next.plane2_stride = cfg_data[pfcw_pkg::STRIDE12_W-1:0];
        default:               cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= pfcw_pkg::MODE_PACKED;
      cfg.swap_outer    <= 1'b0;
      cfg.image_width   <= pfcw_pkg::SIZE_W'(1);
      cfg.image_height  <= pfcw_pkg::SIZE_W'(1);
      cfg.plane0_stride <= '0;
      cfg.plane1_stride <= '0;
      cfg.plane2_stride <= '0;
    end else begin
      cfg <= cfg_next;
    end
  end

  pfcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .pixel      (pixel),
    .queue_full (full),
    .desc_push  (desc_push),
    .desc       (front_desc)
  );

  pfcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (desc_push),
    .push_desc (front_desc),
    .full      (full),
    .pop       (desc_pop),
    .valid     (queue_valid),
    .head      (queue_head)
  );

  pfcw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .desc_valid (queue_valid),
    .desc       (queue_head),
    .desc_pop   (desc_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

  // plane of the waiting result
  assign res_plane0   = result.plane_select == pfcw_pkg::PLANE0;
  assign res_plane1   = !empty && result.plane_select == pfcw_pkg::PLANE1;
  assign res_plane2   = !empty && result.plane_select == pfcw_pkg::PLANE2;
  assign res_plane_ok = res_plane0 || res_plane1 || res_plane2;

  `PFCW_ASSERT_IMPLY(a_plane_in_range, !empty, res_plane_ok, "result plane out of range")
  `PFCW_ASSERT_IMPLY(a_plane2_ends_pixel, res_plane2, result.last_of_pixel, "plane 2 not last")
  `PFCW_ASSERT_NEVER(a_plane1_not_last, res_plane1 && result.last_of_pixel, "plane 1 last")

endmodule

`default_nettype wire
